FILE: rtl/tbb_pkg.sv
package tbb_pkg;

    // fixed-point format of the rotation entries
    localparam int FRACTION_BITS = 14;

    // field widths
    localparam int COORD_W = 32;
    localparam int ENTRY_W = 16;
    localparam int AXES    = 3;
    localparam int ROW_W   = AXES * ENTRY_W;

    // full product, product after the fraction shift, and the per-axis sum
    localparam int PROD_W = COORD_W + ENTRY_W;
    localparam int TERM_W = PROD_W - FRACTION_BITS;
    localparam int SUM_W  = ((TERM_W > COORD_W) ? TERM_W : COORD_W) + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5
    } cfg_reg_t;

    // identity matrix at reset: 1.0 on the diagonal
    localparam logic [ENTRY_W-1:0] ENTRY_ONE = ENTRY_W'(1 << FRACTION_BITS);

    typedef logic [AXES-1:0][COORD_W-1:0] coord_vec_t;
    typedef logic [AXES-1:0][TERM_W-1:0]  term_vec_t;

endpackage

FILE: rtl/tbb_axis_mul.sv
module tbb_axis_mul (
    input  logic                     clk,
    input  logic                     en,
    input  logic [tbb_pkg::ROW_W-1:0] row,
    input  tbb_pkg::coord_vec_t      lo,
    input  tbb_pkg::coord_vec_t      hi,
    output tbb_pkg::term_vec_t       term_lo,
    output tbb_pkg::term_vec_t       term_hi
);
    import tbb_pkg::*;

    term_vec_t term_lo_reg;
    term_vec_t term_hi_reg;
    term_vec_t term_lo_next;
    term_vec_t term_hi_next;

    // one entry times both bounds of its axis, floor-shifted by the fraction width
    always_comb
    begin
        logic signed [ENTRY_W-1:0] entry;
        logic signed [PROD_W-1:0]  prod_lo;
        logic signed [PROD_W-1:0]  prod_hi;
        for (int j = 0; j < AXES; j++)
        begin
            entry   = $signed(row[j*ENTRY_W +: ENTRY_W]);
            prod_lo = PROD_W'(entry) * PROD_W'($signed(lo[j]));
            prod_hi = PROD_W'(entry) * PROD_W'($signed(hi[j]));
            term_lo_next[j] = TERM_W'(prod_lo >>> FRACTION_BITS);
            term_hi_next[j] = TERM_W'(prod_hi >>> FRACTION_BITS);
        end
    end

    // product register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            term_lo_reg <= term_lo_next;
            term_hi_reg <= term_hi_next;
        end
    end

    assign term_lo = term_lo_reg;
    assign term_hi = term_hi_reg;

endmodule

FILE: rtl/tbb_axis_sum.sv
module tbb_axis_sum (
    input  tbb_pkg::term_vec_t          term_a,
    input  tbb_pkg::term_vec_t          term_b,
    input  logic [tbb_pkg::COORD_W-1:0] shift,
    output logic [tbb_pkg::COORD_W-1:0] new_lo,
    output logic [tbb_pkg::COORD_W-1:0] new_hi,
    output logic                        clipped
);
    import tbb_pkg::*;

    logic signed [SUM_W-1:0] sum_min;
    logic signed [SUM_W-1:0] sum_max;
    logic                    ovf_min;
    logic                    ovf_max;

    // per-axis min and max of the two corner terms, summed onto the shift
    always_comb
    begin
        logic signed [TERM_W-1:0] a;
        logic signed [TERM_W-1:0] b;
        sum_min = SUM_W'($signed(shift));
        sum_max = SUM_W'($signed(shift));
        for (int j = 0; j < AXES; j++)
        begin
            a = $signed(term_a[j]);
            b = $signed(term_b[j]);
            if (a < b)
            begin
                sum_min = sum_min + SUM_W'(a);
                sum_max = sum_max + SUM_W'(b);
            end
            else
            begin
                sum_min = sum_min + SUM_W'(b);
                sum_max = sum_max + SUM_W'(a);
            end
        end
    end

    // out of range when the bits above the result sign disagree with it
    assign ovf_min = (sum_min[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){sum_min[SUM_W-1]}});
    assign ovf_max = (sum_max[SUM_W-1:COORD_W-1] != {(SUM_W-COORD_W+1){sum_max[SUM_W-1]}});

    // clamp to the signed coordinate range
    assign new_lo = ovf_min ? {sum_min[SUM_W-1], {(COORD_W-1){~sum_min[SUM_W-1]}}}
                            : sum_min[COORD_W-1:0];
    assign new_hi = ovf_max ? {sum_max[SUM_W-1], {(COORD_W-1){~sum_max[SUM_W-1]}}}
                            : sum_max[COORD_W-1:0];
    assign clipped = ovf_min | ovf_max;

endmodule

FILE: rtl/transform_bounding_box_top.sv
// channel   | dir | tdata (low bit up)                                 | tuser
// ----------+-----+----------------------------------------------------+----------
// s_axis    | in  | lower_x upper_x lower_y upper_y lower_z upper_z    | -
// m_axis    | out | new_lower_x new_upper_x new_lower_y new_upper_y    | saturated
//           |     | new_lower_z new_upper_z                            |
// cfg       | in  | cfg_we, cfg_index (0..5), cfg_data (48 bits)       | -
//
// one beat in and one beat out per cycle while the output is not stalled; an input
// beat passes the input register, product register and result register in turn.
// the 18 multipliers of 16 by 32 bits set the product stage, the adds and
// clamp set the result stage. reset (rst_n, async) loads the identity
// matrix and zero shift and empties the pipeline. a stalled output holds the
// pipeline; bubbles collapse, so input is taken while any stage is free.
module transform_bounding_box_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // lower_x, upper_x, lower_y, upper_y, lower_z, upper_z
    input  logic [191:0]                     s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // new_lower_x, new_upper_x, new_lower_y, new_upper_y, new_lower_z, new_upper_z
    output logic [191:0]                     m_axis_tdata,
    // saturated
    output logic                             m_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_we,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tbb_pkg::*;

    // configuration registers
    logic [AXES-1:0][ROW_W-1:0]   row_reg;
    logic [AXES-1:0][COORD_W-1:0] shift_reg;

    // pipeline control
    logic in_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg;
    logic in_adv;
    logic prod_adv;
    logic out_take;

    // payload
    coord_vec_t                   lo_reg;
    coord_vec_t                   hi_reg;
    logic [AXES-1:0][COORD_W-1:0] new_lo;
    logic [AXES-1:0][COORD_W-1:0] new_hi;
    logic [AXES-1:0]              clipped;
    logic [191:0]                 data_reg;
    logic [191:0]                 data_next;
    logic                         sat_reg;
    term_vec_t                    term_lo [AXES];
    term_vec_t                    term_hi [AXES];

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0]   <= ROW_W'(ENTRY_ONE);
            row_reg[1]   <= ROW_W'(ENTRY_ONE) << ENTRY_W;
            row_reg[2]   <= ROW_W'(ENTRY_ONE) << (2 * ENTRY_W);
            shift_reg[0] <= '0;
            shift_reg[1] <= '0;
            shift_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW_X:   row_reg[0]   <= cfg_data;
                REG_ROW_Y:   row_reg[1]   <= cfg_data;
                REG_ROW_Z:   row_reg[2]   <= cfg_data;
                REG_SHIFT_X: shift_reg[0] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Y: shift_reg[1] <= cfg_data[COORD_W-1:0];
                REG_SHIFT_Z: shift_reg[2] <= cfg_data[COORD_W-1:0];
                default:     ;
            endcase
        end
    end

    // each stage moves when the one after it is empty or moving
    assign out_take      = !out_valid_reg || m_axis_tready;
    assign prod_adv      = !prod_valid_reg || out_take;
    assign in_adv        = !in_valid_reg || prod_adv;
    assign s_axis_tready = in_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_adv)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (prod_adv)
            begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_take)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            for (int j = 0; j < AXES; j++)
            begin
                lo_reg[j] <= s_axis_tdata[2*j*COORD_W +: COORD_W];
                hi_reg[j] <= s_axis_tdata[(2*j+1)*COORD_W +: COORD_W];
            end
        end
    end

    // one multiply stage and one reduce per output axis
    for (genvar i = 0; i < AXES; i++)
    begin : g_axis
        tbb_axis_mul u_mul (
            .clk     (clk),
            .en      (prod_adv),
            .row     (row_reg[i]),
            .lo      (lo_reg),
            .hi      (hi_reg),
            .term_lo (term_lo[i]),
            .term_hi (term_hi[i])
        );

        tbb_axis_sum u_sum (
            .term_a  (term_lo[i]),
            .term_b  (term_hi[i]),
            .shift   (shift_reg[i]),
            .new_lo  (new_lo[i]),
            .new_hi  (new_hi[i]),
            .clipped (clipped[i])
        );
    end

    // pack the result beat
    always_comb
    begin
        for (int j = 0; j < AXES; j++)
        begin
            data_next[2*j*COORD_W +: COORD_W]     = new_lo[j];
            data_next[(2*j+1)*COORD_W +: COORD_W] = new_hi[j];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            data_reg <= data_next;
            sat_reg  <= |clipped;
        end
    end

    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = sat_reg;
    assign m_axis_tvalid = out_valid_reg;

endmodule

FILE: bench/box_transform_checker.sv
`timescale 1ns / 100ps

module box_transform_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [191:0]                   s_axis_tdata,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [191:0]                   m_axis_tdata,
    input  logic                           m_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_we,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             boxes_in_flight,
    output int                             mismatch_count
);
    import tbb_pkg::*;

    // six enclosing bounds packed like tdata, plus the clip flag
    typedef struct packed {
        logic [191:0] bounds;
        logic         clipped;
    } moved_box_t;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic [ROW_W-1:0]   rotation_rows [AXES];
    logic [COORD_W-1:0] shift_by_axis [AXES];
    moved_box_t         moved_boxes [$];
    int                 in_flight  = 0;
    int                 mismatches = 0;
    string              field_names [6] = '{"new_lower_x", "new_upper_x", "new_lower_y",
                                            "new_upper_y", "new_lower_z", "new_upper_z"};

    assign boxes_in_flight = in_flight;
    assign mismatch_count  = mismatches;

    // clip a wide sum into the signed 32-bit range
    function automatic logic [COORD_W-1:0] clamp_coord(input longint sum, inout logic clipped);
        if (sum > SUM_MAX)
        begin
            clipped = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (sum < SUM_MIN)
        begin
            clipped = 1'b1;
            return 32'h8000_0000;
        end
        return sum[COORD_W-1:0];
    endfunction

    // per output axis: shift plus the smaller and larger floored product of each input axis
    function automatic moved_box_t move_box(input logic [191:0] box);
        moved_box_t result;
        longint     entry;
        longint     lo_bound;
        longint     hi_bound;
        longint     lo_term;
        longint     hi_term;
        longint     near_sum;
        longint     far_sum;
        logic       clipped;
        int         row;
        int         col;
        clipped = 1'b0;
        for (row = 0; row < AXES; row++)
        begin
            near_sum = longint'($signed(shift_by_axis[row]));
            far_sum  = near_sum;
            for (col = 0; col < AXES; col++)
            begin
                entry    = longint'($signed(rotation_rows[row][col*ENTRY_W +: ENTRY_W]));
                lo_bound = longint'($signed(box[(2*col)*COORD_W +: COORD_W]));
                hi_bound = longint'($signed(box[(2*col+1)*COORD_W +: COORD_W]));
                lo_term  = (entry * lo_bound) >>> FRACTION_BITS;
                hi_term  = (entry * hi_bound) >>> FRACTION_BITS;
                near_sum += (lo_term < hi_term) ? lo_term : hi_term;
                far_sum  += (lo_term < hi_term) ? hi_term : lo_term;
            end
            result.bounds[(2*row)*COORD_W +: COORD_W]   = clamp_coord(near_sum, clipped);
            result.bounds[(2*row+1)*COORD_W +: COORD_W] = clamp_coord(far_sum, clipped);
        end
        result.clipped = clipped;
        return result;
    endfunction

    // watch the three channels; result beats are matched before new box beats
    always @(posedge clk or negedge rst_n)
    begin
        moved_box_t oldest;
        int         field;
        if (!rst_n)
        begin
            rotation_rows[0] = {16'h0, 16'h0, ENTRY_ONE};
            rotation_rows[1] = {16'h0, ENTRY_ONE, 16'h0};
            rotation_rows[2] = {ENTRY_ONE, 16'h0, 16'h0};
            shift_by_axis[0] = '0;
            shift_by_axis[1] = '0;
            shift_by_axis[2] = '0;
        end
        else
        begin
            // result beat against the oldest box
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (moved_boxes.size() == 0)
                begin
                    $error("result beat with no box in flight: tdata %h", m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    oldest = moved_boxes.pop_front();
                    for (field = 0; field < 6; field++)
                    begin
                        if (m_axis_tdata[field*COORD_W +: COORD_W] !==
                            oldest.bounds[field*COORD_W +: COORD_W])
                        begin
                            $error("%s expected %0d actual %0d", field_names[field],
                                   $signed(oldest.bounds[field*COORD_W +: COORD_W]),
                                   $signed(m_axis_tdata[field*COORD_W +: COORD_W]));
                            mismatches++;
                        end
                    end
                    if (m_axis_tuser !== oldest.clipped)
                    begin
                        $error("saturated expected %0d actual %0d", oldest.clipped,
                               m_axis_tuser);
                        mismatches++;
                    end
                end
            end

            // box beat
            if (s_axis_tvalid && s_axis_tready)
                moved_boxes.push_back(move_box(s_axis_tdata));

            // register write, bits beyond a register's width dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_X:   rotation_rows[0] = cfg_data;
                    REG_ROW_Y:   rotation_rows[1] = cfg_data;
                    REG_ROW_Z:   rotation_rows[2] = cfg_data;
                    REG_SHIFT_X: shift_by_axis[0] = cfg_data[COORD_W-1:0];
                    REG_SHIFT_Y: shift_by_axis[1] = cfg_data[COORD_W-1:0];
                    REG_SHIFT_Z: shift_by_axis[2] = cfg_data[COORD_W-1:0];
                    default:     ;
                endcase
            end

            in_flight = moved_boxes.size();
        end
    end

endmodule

FILE: bench/transform_bounding_box_top_tb.sv
`timescale 1ns / 100ps

module transform_bounding_box_top_tb;
    import tbb_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 8;
    localparam int BOXES_PER_PHASE = 125;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 16'h7FFF;
    localparam logic [ENTRY_W-1:0] ENTRY_MIN = 16'h8000;
    localparam logic [ENTRY_W-1:0] ENTRY_NEG_ONE = 16'hC000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [191:0]          s_axis_tdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [191:0]          m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int boxes_in_flight;
    int mismatch_count;
    int cycle_count = 0;
    int boxes_sent = 0;
    int settings_loaded = 0;
    int hold_left = 0;
    bit idle_on = 1'b1;

    transform_bounding_box_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    box_transform_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .boxes_in_flight (boxes_in_flight),
        .mismatch_count  (mismatch_count)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when requested
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on)
                m_axis_tready <= ($urandom_range(99) >= 36);
            else
                m_axis_tready <= 1'b1;
        end
    end

    // one register write; the caller lowers cfg_we after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // full transform load; junk in the unused shift bits and at unmapped indexes
    task automatic load_transform(input logic [ROW_W-1:0] row_x, input logic [ROW_W-1:0] row_y,
                                  input logic [ROW_W-1:0] row_z, input logic [COORD_W-1:0] sx,
                                  input logic [COORD_W-1:0] sy, input logic [COORD_W-1:0] sz);
        write_reg(REG_ROW_X, row_x);
        write_reg(REG_ROW_Y, row_y);
        write_reg(REG_ROW_Z, row_z);
        write_reg(REG_SHIFT_X, {16'($urandom), sx});
        write_reg(REG_SHIFT_Y, {16'($urandom), sy});
        write_reg(REG_SHIFT_Z, {16'($urandom), sz});
        write_reg(REG_UNMAPPED_6, {16'($urandom), 32'($urandom)});
        write_reg(REG_UNMAPPED_7, {16'($urandom), 32'($urandom)});
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // offer one box beat, with random gaps before it
    task automatic send_box(input logic [191:0] box);
        while (idle_on && $urandom_range(99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= box;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        boxes_sent++;
    endtask

    // stop offering and let every box come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (boxes_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [191:0] make_box(input logic [COORD_W-1:0] lx, ux, ly, uy, lz, uz);
        return {uz, lz, uy, ly, ux, lx};
    endfunction

    // mostly full-range, some small values in -2000..2000
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return 32'($urandom_range(4000)) - 32'd2000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ENTRY_W-1:0] rand_entry();
        case ($urandom_range(9))
            0:       return ENTRY_MIN;
            1:       return ENTRY_MAX;
            2:       return '0;
            3:       return ENTRY_ONE;
            4:       return ENTRY_NEG_ONE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        return {rand_entry(), rand_entry(), rand_entry()};
    endfunction

    function automatic logic [COORD_W-1:0] rand_shift();
        case ($urandom_range(7))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return 32'($urandom_range(2000)) - 32'd1000;
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial
    begin
        int phase;
        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity transform straight out of reset
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        // inverted bounds on every axis
        send_box(make_box(1000, -1000, 5, -5, 7, 3));
        settle();

        // every entry -2.0, largest shift: clips upward
        load_transform({3{ENTRY_MIN}}, {3{ENTRY_MIN}}, {3{ENTRY_MIN}},
                       COORD_MAX, COORD_MAX, COORD_MAX);
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-1, 1, -1, 1, -1, 1));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(make_box(20000, -20000, 3, -3, 1, -1));
        settle();

        // largest positive entries, smallest shift: clips downward
        load_transform({3{ENTRY_MAX}}, {3{ENTRY_MAX}}, {3{ENTRY_MAX}},
                       COORD_MIN, COORD_MIN, COORD_MIN);
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(-1, 1, -1, 1, -1, 1));
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_box(make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
        settle();

        // mixed signs on one row, zero rows elsewhere
        load_transform({ENTRY_ONE, ENTRY_NEG_ONE, 16'h0}, '0, '0,
                       $urandom, $urandom, $urandom);
        send_box(make_box(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 100, -100));
        send_box(make_box(-7, 9, 12, -12, COORD_MIN, COORD_MIN));
        settle();

        // random transforms; one phase with no gaps, one with a long output hold-off
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_transform(rand_row(), rand_row(), rand_row(),
                           rand_shift(), rand_shift(), rand_shift());
            idle_on = (phase != 5);
            if (phase == 2)
                hold_left = HOLD_CYCLES;
            repeat (BOXES_PER_PHASE)
                send_box(make_box(rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord()));
            settle();
        end

        $display("%0d boxes through %0d transform settings, extreme entries and shifts",
                 boxes_sent, settings_loaded);
        $display("with random gaps, a gap-free phase and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
